// File: rtl/ise_pkg.sv
// shared types, constants and tables of the isometric tile sprite emitter
package ise_pkg;

  localparam int MAP_SIDE  = 1024;
  localparam int MAX_WALLS = 63;

  // coordinate compare width, wide enough for the largest map side
  localparam int CMP_W   = 13;
  localparam int CNT_W   = $clog2(MAX_WALLS + 1);
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [15:0] SEA_Q16    = 16'd26214;
  localparam logic [8:0]  SHEET_UNIT = 9'd64;
  localparam logic [8:0]  WALL_SHEET = 9'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM     = 3'd0,
    REG_CAMERA_X = 3'd1,
    REG_CAMERA_Y = 3'd2,
    REG_VIEW_W   = 3'd3,
    REG_VIEW_H   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  typedef struct packed {
    word_t res;
    logic  neg;
  } alu_rsp_t;

  typedef struct packed {
    logic [9:0]  tile_col;
    logic [9:0]  tile_row;
    logic [15:0] tile_height;
    logic [15:0] right_height;
    logic [15:0] below_height;
    logic        right_present;
    logic        below_present;
    logic [3:0]  biome_code;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         sheet_x;
    logic signed [19:0] screen_x;
    logic signed [19:0] screen_y;
    logic               is_roof;
    logic               run_last;
  } out_item_t;

  // roof sprite column by biome, unknown biomes fall back to ocean
  function automatic logic [8:0] roof_sheet(input logic [3:0] biome);
    logic [8:0] col;
    case (biome)
      4'd1, 4'd2: col = 9'd1;
      4'd3, 4'd4: col = 9'd2;
      4'd5:       col = 9'd3;
      4'd6:       col = 9'd4;
      4'd7:       col = 9'd5;
      4'd8:       col = 9'd6;
      default:    col = 9'd0;
    endcase
    return 9'(col * SHEET_UNIT);
  endfunction

endpackage

// File: rtl/ise_alu.sv
// shared add, subtract and multiply unit
module ise_alu
  import ise_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  word_t res;
  word_t prod;
  logic signed [15:0] ma;
  logic signed [15:0] mb;

  assign ma = req.a[15:0];
  assign mb = req.b[15:0];

  // signed operands widen to the full word before the multiply
  assign prod = ma * mb;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      ALU_MUL: res = prod;
      default: res = req.a;
    endcase
  end

  assign rsp.res = res;
  assign rsp.neg = res[WORD_W-1];

endmodule

// File: rtl/iso_tile_sprite_emitter.sv
// top level: sequencer of the isometric tile sprite emitter
// one tile request enters on in_data when in_valid is high and in_stall is low
// in_stall stays high while a tile is worked on, so one tile is in the block at a time
// a small sequencer steps one shared add/subtract/multiply unit through the projection
// (two multiplies by zoom, camera and centre offsets, elevation subtraction, truncation
// toward zero), then four culling compares, then the wall run and the roof
// the roof is loaded into the output register after the last wall; each wall passes through
// a run check, a row subtract, a truncate and emit step and an elevation step
// a tile holds the block until its roof is emitted or it is culled; no new request is taken
// before then, and a culled tile frees the block once a culling compare fails
// results leave through one output register on out_data/out_valid; while out_stall holds
// that register the sequencer waits at its emit step, so no sprite is lost
// configuration writes on cfg_valid/cfg_ready are always taken and should be made only
// while the block is idle; unknown indexes are dropped
// reset (rst_n low, synchronous) restores zoom 64, camera 0,0 and a 640x480 window, and
// empties the sequencer and output register
module iso_tile_sprite_emitter
  import ise_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_SX1, ST_SX2, ST_SXD, ST_MY, ST_BY1, ST_BYD,
    ST_RY, ST_RYD, ST_BT, ST_BTD, ST_C1, ST_C2, ST_C3, ST_C4,
    ST_WCHK, ST_WY, ST_WYD, ST_WINC, ST_ROOF
  } state_t;

  state_t state_r;

  // configuration
  logic [8:0]         zoom_r;
  logic signed [17:0] cam_x_r;
  logic signed [17:0] cam_y_r;
  logic [11:0]        view_w_r;
  logic [11:0]        view_h_r;

  // tile working registers
  logic signed [10:0] diff_r;     // col - row
  logic [10:0]        sum_r;      // col + row
  logic [14:0]        elev_r;     // own elevation, q.8
  logic [14:0]        low_r;      // lowest elevation, q.8
  logic [3:0]         biome_r;
  word_t              t_r;        // scratch result of the shared unit
  logic signed [19:0] sx_r;
  logic signed [19:0] base_r;
  logic signed [19:0] roof_y_r;
  logic signed [19:0] bottom_y_r;
  logic [16:0]        e_r;        // wall elevation walker, q.8
  logic [CNT_W-1:0]   count_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  ise_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // elevation above sea level in q.8, exact form of (a - 0.4) * 120 * 256
  function automatic logic [14:0] elev_q8(input logic [15:0] alt);
    logic [20:0] m;
    m = ((21'(alt) * 21'd5) - 21'd131072) * 21'd3;
    if (alt <= SEA_Q16) return 15'd0;
    return m[19:5];
  endfunction

  function automatic word_t sx20(input logic signed [19:0] v);
    return {{(WORD_W-20){v[19]}}, v};
  endfunction

  logic [14:0] own_e;
  logic [14:0] right_e;
  logic [14:0] below_e;
  logic [14:0] low_e;
  logic        right_ok;
  logic        below_ok;
  logic        off_map;
  logic        in_acc;
  logic        out_free;
  logic        emit_wall;
  logic        emit_roof;
  logic [14:0] step_q8;
  logic [6:0]  step_px;
  logic        cfg_acc;
  word_t       corr;
  word_t       base_q8;   // base row in q.8

  assign own_e   = elev_q8(in_data.tile_height);
  assign right_e = elev_q8(in_data.right_height);
  assign below_e = elev_q8(in_data.below_height);

  // a neighbour past the map edge counts as absent
  assign right_ok = in_data.right_present &&
                    ((CMP_W'(in_data.tile_col) + CMP_W'(1)) < CMP_W'(MAP_SIDE));
  assign below_ok = in_data.below_present &&
                    ((CMP_W'(in_data.tile_row) + CMP_W'(1)) < CMP_W'(MAP_SIDE));
  assign off_map  = (CMP_W'(in_data.tile_col) >= CMP_W'(MAP_SIDE)) ||
                    (CMP_W'(in_data.tile_row) >= CMP_W'(MAP_SIDE));

  always_comb begin
    low_e = own_e;
    if (right_ok && (right_e < low_e)) low_e = right_e;
    if (below_ok && (below_e < low_e)) low_e = below_e;
  end

  // wall step is zoom/4 pixels, never below one
  assign step_px = (zoom_r[8:2] == 7'd0) ? 7'd1 : zoom_r[8:2];
  assign step_q8 = {step_px, 8'd0};

  assign base_q8 = {{(WORD_W-28){base_r[19]}}, base_r, 8'd0};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_wall = (state_r == ST_WYD) && out_free;
  assign emit_roof = (state_r == ST_ROOF) && out_free;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // rounding bias for truncation toward zero of a negative scratch value
  always_comb begin
    case (state_r)
      ST_SXD:  corr = t_r[WORD_W-1] ? word_t'(1) : word_t'(0);
      ST_BYD:  corr = t_r[WORD_W-1] ? word_t'(3) : word_t'(0);
      default: corr = t_r[WORD_W-1] ? word_t'(255) : word_t'(0);
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = t_r;
    alu_req.b  = word_t'(0);
    case (state_r)
      ST_MX: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = {{(WORD_W-11){diff_r[10]}}, diff_r};
        alu_req.b  = word_t'(zoom_r);
      end
      ST_SX1: alu_req.b = word_t'(view_w_r);
      ST_SX2: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {{(WORD_W-19){cam_x_r[17]}}, cam_x_r, 1'b0};
      end
      ST_MY: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = word_t'(sum_r);
        alu_req.b  = word_t'(zoom_r);
      end
      ST_BY1: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {{(WORD_W-20){cam_y_r[17]}}, cam_y_r, 2'b00};
      end
      ST_RY: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = base_q8;
        alu_req.b  = word_t'(elev_r);
      end
      ST_BT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = base_q8;
        alu_req.b  = word_t'(low_r);
      end
      ST_WY: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = base_q8;
        alu_req.b  = word_t'(e_r);
      end
      ST_SXD, ST_BYD, ST_RYD, ST_BTD, ST_WYD: begin
        alu_req.b = corr;
      end
      ST_C1: begin
        alu_req.a = sx20(sx_r);
        alu_req.b = word_t'(zoom_r);
      end
      ST_C2: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = word_t'(view_w_r);
        alu_req.b  = sx20(sx_r);
      end
      ST_C3: begin
        alu_req.a = sx20(bottom_y_r);
        alu_req.b = word_t'(zoom_r);
      end
      ST_C4: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = word_t'(view_h_r);
        alu_req.b  = sx20(roof_y_r);
      end
      ST_WCHK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = word_t'(e_r);
        alu_req.b  = word_t'(elev_r);
      end
      ST_WINC: begin
        alu_req.a = word_t'(e_r);
        alu_req.b = word_t'(step_q8);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      zoom_r      <= 9'd64;
      cam_x_r     <= 18'sd0;
      cam_y_r     <= 18'sd0;
      view_w_r    <= 12'd640;
      view_h_r    <= 12'd480;
      count_r     <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_ZOOM:     zoom_r   <= cfg_data[8:0];
          REG_CAMERA_X: cam_x_r  <= cfg_data[17:0];
          REG_CAMERA_Y: cam_y_r  <= cfg_data[17:0];
          REG_VIEW_W:   view_w_r <= cfg_data[11:0];
          REG_VIEW_H:   view_h_r <= cfg_data[11:0];
          default: ;
        endcase
      end

      // output register: drains on a take, loads on an emit
      if (emit_wall || emit_roof) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit_wall) begin
        out_data_r.sheet_x  <= WALL_SHEET;
        out_data_r.screen_x <= sx_r;
        out_data_r.screen_y <= alu_rsp.res[27:8];
        out_data_r.is_roof  <= 1'b0;
        out_data_r.run_last <= 1'b0;
      end
      if (emit_roof) begin
        out_data_r.sheet_x  <= roof_sheet(biome_r);
        out_data_r.screen_x <= sx_r;
        out_data_r.screen_y <= roof_y_r;
        out_data_r.is_roof  <= 1'b1;
        out_data_r.run_last <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            diff_r  <= 11'(signed'({1'b0, in_data.tile_col}) -
                           signed'({1'b0, in_data.tile_row}));
            sum_r   <= 11'(in_data.tile_col) + 11'(in_data.tile_row);
            elev_r  <= own_e;
            low_r   <= low_e;
            biome_r <= in_data.biome_code;
            // a tile beyond the map gives nothing
            if (!off_map) state_r <= ST_MX;
          end
        end
        ST_MX:  begin t_r <= alu_rsp.res; state_r <= ST_SX1; end
        ST_SX1: begin t_r <= alu_rsp.res; state_r <= ST_SX2; end
        ST_SX2: begin t_r <= alu_rsp.res; state_r <= ST_SXD; end
        ST_SXD: begin sx_r <= alu_rsp.res[20:1]; state_r <= ST_MY; end
        ST_MY:  begin t_r <= alu_rsp.res; state_r <= ST_BY1; end
        ST_BY1: begin t_r <= alu_rsp.res; state_r <= ST_BYD; end
        ST_BYD: begin base_r <= alu_rsp.res[21:2]; state_r <= ST_RY; end
        ST_RY:  begin t_r <= alu_rsp.res; state_r <= ST_RYD; end
        ST_RYD: begin roof_y_r <= alu_rsp.res[27:8]; state_r <= ST_BT; end
        ST_BT:  begin t_r <= alu_rsp.res; state_r <= ST_BTD; end
        ST_BTD: begin bottom_y_r <= alu_rsp.res[27:8]; state_r <= ST_C1; end
        // culling compares: any negative outcome drops the tile
        ST_C1: state_r <= alu_rsp.neg ? ST_IDLE : ST_C2;
        ST_C2: state_r <= alu_rsp.neg ? ST_IDLE : ST_C3;
        ST_C3: state_r <= alu_rsp.neg ? ST_IDLE : ST_C4;
        ST_C4: begin
          e_r     <= 17'(low_r);
          count_r <= '0;
          state_r <= alu_rsp.neg ? ST_IDLE : ST_WCHK;
        end
        ST_WCHK: begin
          // keep walking while below the roof and under the wall cap
          if (alu_rsp.neg && (count_r < CNT_W'(MAX_WALLS))) state_r <= ST_WY;
          else state_r <= ST_ROOF;
        end
        ST_WY: begin t_r <= alu_rsp.res; state_r <= ST_WYD; end
        ST_WYD: begin
          if (out_free) state_r <= ST_WINC;
        end
        ST_WINC: begin
          e_r     <= alu_rsp.res[16:0];
          count_r <= count_r + CNT_W'(1);
          state_r <= ST_WCHK;
        end
        ST_ROOF: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
